@@ rtl/kla_pkg.sv @@
// shared types and constants for the keypad latch and auto-repeat block
package kla_pkg;

  localparam int NUM_KEYS = 11;

  localparam int KEY_W    = 16;
  localparam int TICK_W   = 8;
  localparam int OP_W     = 2;
  localparam int DELAY_W  = 7;
  localparam int CFG_DW   = 32;
  localparam int CFG_AW   = 4;
  localparam int REG_IW   = CFG_AW - 2;

  localparam logic [OP_W-1:0] OP_SCAN   = 2'd0;
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [REG_IW-1:0] REG_REMAP      = 2'd0;
  localparam logic [REG_IW-1:0] REG_FIRST_DLY  = 2'd1;
  localparam logic [REG_IW-1:0] REG_NEXT_DLY   = 2'd2;

  localparam logic [DELAY_W-1:0] FIRST_DLY_RST = 7'd18;
  localparam logic [DELAY_W-1:0] NEXT_DLY_RST  = 7'd5;

  typedef struct packed {
    logic               remap;
    logic [DELAY_W-1:0] first_delay;
    logic [DELAY_W-1:0] next_delay;
  } cfg_t;

endpackage

@@ rtl/kla_if.sv @@
// item channel interfaces: scan/update input and result output
interface kla_in_if;
  logic                           valid;
  logic                           ready;
  logic [kla_pkg::OP_W-1:0]       opcode;
  logic [kla_pkg::KEY_W-1:0]      raw_keys;
  logic [kla_pkg::TICK_W-1:0]     frame_tick;

  modport source(output valid, opcode, raw_keys, frame_tick, input ready);
  modport sink(input valid, opcode, raw_keys, frame_tick, output ready);
endinterface

interface kla_out_if;
  logic                           valid;
  logic                           ready;
  logic [kla_pkg::KEY_W-1:0]      latched_keys;
  logic [kla_pkg::KEY_W-1:0]      press_events;
  logic [kla_pkg::KEY_W-1:0]      held_keys;

  modport source(output valid, latched_keys, press_events, held_keys, input ready);
  modport sink(input valid, latched_keys, press_events, held_keys, output ready);
endinterface

@@ rtl/kla_cfg_regs.sv @@
// apb-style configuration registers: remap enable and repeat delays
module kla_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kla_pkg::CFG_AW-1:0]    paddr,
  input  logic [kla_pkg::CFG_DW-1:0]    pwdata,
  output logic [kla_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready,
  output kla_pkg::cfg_t                 cfg
);

  kla_pkg::cfg_t              cfg_r, cfg_nxt;
  logic [kla_pkg::REG_IW-1:0] reg_idx;
  logic                       wr_en;

  assign reg_idx = paddr[kla_pkg::CFG_AW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        kla_pkg::REG_REMAP:     cfg_nxt.remap       = pwdata[0];
        kla_pkg::REG_FIRST_DLY: cfg_nxt.first_delay = pwdata[kla_pkg::DELAY_W-1:0];
        kla_pkg::REG_NEXT_DLY:  cfg_nxt.next_delay  = pwdata[kla_pkg::DELAY_W-1:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      kla_pkg::REG_REMAP:     prdata = {{(kla_pkg::CFG_DW-1){1'b0}}, cfg_r.remap};
      kla_pkg::REG_FIRST_DLY: prdata = {{(kla_pkg::CFG_DW-kla_pkg::DELAY_W){1'b0}},
                                        cfg_r.first_delay};
      kla_pkg::REG_NEXT_DLY:  prdata = {{(kla_pkg::CFG_DW-kla_pkg::DELAY_W){1'b0}},
                                        cfg_r.next_delay};
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.remap       <= 1'b0;
      cfg_r.first_delay <= kla_pkg::FIRST_DLY_RST;
      cfg_r.next_delay  <= kla_pkg::NEXT_DLY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ rtl/keypad_latch_autorepeat_top.sv @@
// top level: keypad latches, key walk sequencer with shared 8-bit adder, result register
//
//  channel   dir   handshake             payload
//  in_ch     in    valid/ready           opcode, raw_keys, frame_tick
//  out_ch    out   valid/ready           latched_keys, press_events, held_keys
//  cfg_*     in    apb psel/penable      paddr, pwdata / prdata, pready tied high
//
// a scan or clear item is accepted, then loaded into the result register
// an update item is accepted, then walks the keys in order (the key walk shares a
// single 8-bit add/subtract unit), takes a deadline reload step when a key fires
// or repeats, and ends with the result load
// in_ch.ready is high only while idle; a new item may be taken while the last
// result still waits on out_ch, a finished item then waits until out_ch is free
// rst_n is synchronous, active low; it clears latches, held and press masks,
// the sequencer and out_ch.valid; per-key deadlines come up undefined and are
// only read once written
module keypad_latch_autorepeat_top #(
  parameter int NUM_KEYS = kla_pkg::NUM_KEYS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  kla_in_if.sink                       in_ch,
  kla_out_if.source                    out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [kla_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [kla_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [kla_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);

  localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int CW = $clog2(NUM_KEYS + 1);
  localparam int KEY_W  = kla_pkg::KEY_W;
  localparam int TICK_W = kla_pkg::TICK_W;
  // keys live at bits 1 .. NUM_KEYS
  localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'(((1 << NUM_KEYS) - 1) << 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_LOAD = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  // alternate console layout into the standard bit positions
  function automatic logic [KEY_W-1:0] remap_layout(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] r;
    r     = '0;
    r[12] = k[11];
    r[3]  = k[10];
    r[2]  = k[8];
    r[6]  = k[7];
    r[1]  = k[6];
    r[7]  = k[3];
    r[4]  = k[2];
    r[5]  = k[0];
    return r;
  endfunction

  kla_pkg::cfg_t cfg;

  kla_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  state_t              state_r, state_nxt;
  logic [KEY_W-1:0]    seen_r, seen_nxt;
  logic [KEY_W-1:0]    repress_r, repress_nxt;
  logic [KEY_W-1:0]    release_r, release_nxt;
  logic [KEY_W-1:0]    held_r, held_nxt;
  logic [KEY_W-1:0]    press_r, press_nxt;
  logic [CW-1:0]       key_cnt_r, key_cnt_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt;
  logic                ld_first_r, ld_first_nxt;
  logic [TICK_W-1:0]   deadline_r [NUM_KEYS];

  logic                out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0]    out_latched_r, out_press_r, out_held_r;
  logic                out_load;

  logic                in_acc;
  logic [KEY_W-1:0]    sample;
  logic [KW-1:0]       key_idx;
  logic [KEY_W-1:0]    key_bit;
  logic                last_key;
  logic                expired;
  logic                dl_we;
  logic                go_on;
  logic                fire_load;

  // shared add/subtract unit: deadline - tick during the walk, tick + delay on reload
  logic [TICK_W-1:0]           au_a, au_b, au_sum;
  logic                        au_cin;
  logic [kla_pkg::DELAY_W-1:0] ld_delay;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign key_idx  = key_cnt_r[KW-1:0];
  assign key_bit  = KEY_W'(2) << key_idx;
  assign last_key = (key_cnt_r == CW'(NUM_KEYS - 1));
  assign ld_delay = ld_first_r ? cfg.first_delay : cfg.next_delay;

  always_comb begin
    if (state_r == S_LOAD) begin
      au_a   = tick_r;
      au_b   = {{(TICK_W-kla_pkg::DELAY_W){1'b0}}, ld_delay};
      au_cin = 1'b0;
    end else begin
      au_a   = deadline_r[key_idx];
      au_b   = ~tick_r;
      au_cin = 1'b1;
    end
    au_sum = au_a + au_b + TICK_W'(au_cin);
  end

  // half-range compare: not expired while (deadline - tick) mod 256 < 0x80
  assign expired = au_sum[TICK_W-1];
  assign sample  = cfg.remap ? remap_layout(in_ch.raw_keys) : in_ch.raw_keys;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt    = state_r;
    seen_nxt     = seen_r;
    repress_nxt  = repress_r;
    release_nxt  = release_r;
    held_nxt     = held_r;
    press_nxt    = press_r;
    key_cnt_nxt  = key_cnt_r;
    tick_nxt     = tick_r;
    ld_first_nxt = ld_first_r;
    dl_we        = 1'b0;
    go_on        = 1'b0;
    fire_load    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_DONE;
          case (in_ch.opcode)
            kla_pkg::OP_SCAN: begin
              seen_nxt    = seen_r | sample;
              repress_nxt = repress_r | (sample & release_r);
              release_nxt = release_r | (held_r & ~sample);
            end
            kla_pkg::OP_UPDATE: begin
              state_nxt   = S_WALK;
              press_nxt   = '0;
              key_cnt_nxt = '0;
              tick_nxt    = in_ch.frame_tick;
            end
            kla_pkg::OP_CLEAR: begin
              seen_nxt    = '0;
              repress_nxt = '0;
              release_nxt = '0;
            end
            default: begin
              // unused code reports the current state
            end
          endcase
        end
      end

      S_WALK: begin
        if ((seen_r & key_bit) == '0) begin
          held_nxt = held_r & ~key_bit;
          go_on    = 1'b1;
        end else if ((repress_r & key_bit) != '0) begin
          fire_load    = 1'b1;
          ld_first_nxt = 1'b1;
          press_nxt    = press_r | key_bit;
          held_nxt     = held_r | key_bit;
        end else if ((held_r & key_bit) != '0) begin
          if ((release_r & key_bit) != '0) begin
            held_nxt = held_r & ~key_bit;
          end
          if (!expired) begin
            go_on = 1'b1;
          end else if ((release_r & key_bit) == '0) begin
            // repeat
            fire_load    = 1'b1;
            ld_first_nxt = 1'b0;
            press_nxt    = press_r | key_bit;
          end
        end else if ((release_r & key_bit) == '0) begin
          fire_load    = 1'b1;
          ld_first_nxt = 1'b1;
          press_nxt    = press_r | key_bit;
          held_nxt     = held_r | key_bit;
        end

        if (fire_load) begin
          state_nxt = S_LOAD;
        end else if (go_on && !last_key) begin
          key_cnt_nxt = key_cnt_r + CW'(1);
        end else begin
          state_nxt   = S_DONE;
          seen_nxt    = '0;
          repress_nxt = '0;
          release_nxt = '0;
        end
      end

      S_LOAD: begin
        dl_we       = 1'b1;
        state_nxt   = S_DONE;
        seen_nxt    = '0;
        repress_nxt = '0;
        release_nxt = '0;
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.valid && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seen_r      <= '0;
      repress_r   <= '0;
      release_r   <= '0;
      held_r      <= '0;
      press_r     <= '0;
      key_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seen_r      <= seen_nxt;
      repress_r   <= repress_nxt;
      release_r   <= release_nxt;
      held_r      <= held_nxt;
      press_r     <= press_nxt;
      key_cnt_r   <= key_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    tick_r     <= tick_nxt;
    ld_first_r <= ld_first_nxt;
    if (dl_we) begin
      deadline_r[key_idx] <= au_sum;
    end
    if (out_load) begin
      out_latched_r <= seen_r;
      out_press_r   <= press_r;
      out_held_r    <= held_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.latched_keys = out_latched_r;
  assign out_ch.press_events = out_press_r;
  assign out_ch.held_keys    = out_held_r;

  // walk index stays inside the key range
  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK || state_r == S_LOAD) |-> key_cnt_r < CW'(NUM_KEYS))
    else $error("key walk index out of range");

  // a scan or clear item goes straight to the result stage
  a_short_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.opcode != kla_pkg::OP_UPDATE) |=> state_r == S_DONE)
    else $error("non-update item did not finish in one cycle");

  // one update fires or repeats at most one key, and only keys in range
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(press_r) <= 1) && ((press_r & ~KEY_MASK) == '0))
    else $error("press events hold more than one key");

  // held keys never leave the key range
  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    (held_r & ~KEY_MASK) == '0)
    else $error("held bit outside key range");

  // a deadline reload ends the update with the latches cleared
  a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOAD |=> (seen_r == '0 && repress_r == '0 && release_r == '0
                           && state_r == S_DONE))
    else $error("latches not cleared after update");

endmodule
